>>> design/lsf_pkg.sv
// Label swap forwarding: shared types and codes.
// Used by every module of the block; depends on nothing.
package lsf_pkg;

  localparam int unsigned PortW  = 4;
  localparam int unsigned PortCnt = 16;
  localparam int unsigned LabelW = 64;

  typedef enum logic [1:0] {
    CMD_FWD   = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_DOWN  = 2'd2,
    CMD_NONE  = 2'd3
  } lsf_cmd_e;

  typedef enum logic [3:0] {
    V_FWD          = 4'd0,
    V_FWD_EXIT     = 4'd1,
    V_BACK_EXIT    = 4'd2,
    V_MISS_DROP    = 4'd3,
    V_TARGET_DOWN  = 4'd4,
    V_MALFORMED    = 4'd5,
    V_STORED       = 4'd6,
    V_DUPLICATE    = 4'd7,
    V_FULL         = 4'd8,
    V_PORT_DOWNED  = 4'd9
  } lsf_verdict_e;

  typedef enum logic [0:0] {
    REG_BACK_EN   = 1'd0,
    REG_EXIT_MASK = 1'd1
  } lsf_reg_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [PortW-1:0]  in_port;
    logic [LabelW-1:0] in_label;
    logic              frame_ok;
    logic [PortW-1:0]  target_port;
    logic [LabelW-1:0] target_label;
  } lsf_req_t;

  typedef struct packed {
    lsf_verdict_e      verdict;
    logic [PortW-1:0]  dest_port;
    logic [LabelW-1:0] out_label;
    logic              exit_mark;
  } lsf_res_t;

  // request walking down the cell row, with what it has picked up so far
  typedef struct packed {
    logic              vld;
    lsf_req_t          req;
    logic              hit;
    logic [PortW-1:0]  hit_dest;
    logic [LabelW-1:0] hit_label;
    logic              stored;
  } lsf_token_t;

  typedef struct packed {
    logic               back_en;
    logic [PortCnt-1:0] exit_mask;
  } lsf_cfg_t;

endpackage

>>> design/lsf_cell.sv
// One route entry of the cell row: holds the entry, matches the passing
// request against it and claims the slot for a route write. Uses lsf_pkg.
module lsf_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  lsf_pkg::lsf_token_t tok_i,
  output lsf_pkg::lsf_token_t tok_o
);
  import lsf_pkg::*;

  logic              ent_vld_q;
  logic [PortW-1:0]  key_port_q;
  logic [LabelW-1:0] key_label_q;
  logic [PortW-1:0]  dest_q;
  logic [LabelW-1:0] new_label_q;
  lsf_token_t        tok_q, tok_d;
  logic              match, take;

  assign match = ent_vld_q && (key_port_q == tok_i.req.in_port) &&
                 (key_label_q == tok_i.req.in_label);
  // entries fill from the bottom and never leave, so the first free cell
  // reached without a hit is the lowest free slot and no duplicate lies beyond
  assign take  = tok_i.vld && (tok_i.req.command == CMD_WRITE) && !ent_vld_q &&
                 !tok_i.hit && !tok_i.stored;

  always_comb begin
    tok_d = tok_i;
    if (tok_i.vld && match && !tok_i.hit) begin
      tok_d.hit       = 1'b1;
      tok_d.hit_dest  = dest_q;
      tok_d.hit_label = new_label_q;
    end
    if (take) begin
      tok_d.stored = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= 1'b0;
      tok_q     <= '0;
    end else if (adv_i) begin
      tok_q <= tok_d;
      if (take) begin
        ent_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (take) begin
        key_port_q  <= tok_i.req.in_port;
        key_label_q <= tok_i.req.in_label;
        dest_q      <= tok_i.req.target_port;
        new_label_q <= tok_i.req.target_label;
      end
    end
  end

  assign tok_o = tok_q;

endmodule

>>> design/lsf_resolve.sv
// End of the cell row: port disconnect mask, final verdict and the output
// register. Uses lsf_pkg.
module lsf_resolve #(
  parameter int unsigned NUM_PORTS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  lsf_pkg::lsf_cfg_t   cfg_i,
  input  lsf_pkg::lsf_token_t tok_i,
  output logic                out_valid_o,
  output lsf_pkg::lsf_res_t   out_res_o
);
  import lsf_pkg::*;

  localparam int unsigned MaskW = (NUM_PORTS < PortCnt) ? NUM_PORTS : PortCnt;

  logic [MaskW-1:0]   down_q, down_d;
  logic [PortCnt-1:0] port_ok, down_vec, exit_vec;
  logic               out_valid_q;
  lsf_res_t           res_q, res_d;
  lsf_req_t           rq;

  for (genvar i = 0; i < PortCnt; i++) begin : g_port
    if (i < MaskW) begin : g_in
      assign port_ok[i]  = 1'b1;
      assign down_vec[i] = down_q[i];
    end else begin : g_out
      assign port_ok[i]  = 1'b0;
      assign down_vec[i] = 1'b0;
    end
  end

  assign exit_vec = cfg_i.exit_mask & port_ok;
  assign rq       = tok_i.req;

  always_comb begin
    down_d = down_q;
    for (int i = 0; i < MaskW; i++) begin
      if (tok_i.vld && (rq.command == CMD_DOWN) && (rq.in_port == PortW'(i))) begin
        down_d[i] = 1'b1;
      end
    end
  end

  always_comb begin
    res_d.verdict   = V_PORT_DOWNED;
    res_d.dest_port = '0;
    res_d.out_label = '0;
    res_d.exit_mark = 1'b0;
    case (rq.command)
      CMD_FWD: begin
        if (!rq.frame_ok) begin
          res_d.verdict = V_MALFORMED;
        end else if (tok_i.hit) begin
          if (!port_ok[tok_i.hit_dest] || down_vec[tok_i.hit_dest]) begin
            res_d.verdict = V_TARGET_DOWN;
          end else begin
            res_d.dest_port = tok_i.hit_dest;
            res_d.out_label = tok_i.hit_label;
            if (exit_vec[tok_i.hit_dest]) begin
              res_d.verdict   = V_FWD_EXIT;
              res_d.exit_mark = 1'b1;
            end else begin
              res_d.verdict = V_FWD;
            end
          end
        end else if (cfg_i.back_en) begin
          res_d.verdict   = V_BACK_EXIT;
          res_d.dest_port = rq.in_port;
          res_d.out_label = rq.in_label;
          res_d.exit_mark = 1'b1;
        end else begin
          res_d.verdict = V_MISS_DROP;
        end
      end
      CMD_WRITE: begin
        if (tok_i.hit) begin
          res_d.verdict = V_DUPLICATE;
        end else if (tok_i.stored) begin
          res_d.verdict = V_STORED;
        end else begin
          res_d.verdict = V_FULL;
        end
      end
      default: begin
        res_d.verdict = V_PORT_DOWNED;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      down_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      down_q      <= down_d;
      out_valid_q <= tok_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

endmodule

>>> design/label_swap_forwarding.sv
// Label swap forwarding decision. Each request (frame lookup, route write or
// port disconnect) enters a row of ROUTE_ENTRIES cells, one route entry per
// cell, and moves one cell per cycle while the output is not stalled; the last
// cell feeds a resolve stage with the output register. A new request is taken
// every cycle unless the output stalls, and its result passes through the
// ROUTE_ENTRIES cell registers and then the output register. Requests keep
// their order through the row, so a write is seen by every later lookup. An
// output stall freezes the whole row and shows on in_stall_o. Valid bits live
// in the cells and clear at reset, so the block is ready straight after reset
// with no clearing pass. Depends on lsf_pkg, lsf_cell and lsf_resolve.
module label_swap_forwarding #(
  parameter int unsigned NUM_PORTS     = 16,
  parameter int unsigned ROUTE_ENTRIES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lsf_pkg::lsf_req_t in_req_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lsf_pkg::lsf_res_t out_res_o,
  // configuration writes
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_idx_i,
  input  logic [15:0]       cfg_wdata_i
);
  import lsf_pkg::*;

  lsf_token_t chain [ROUTE_ENTRIES+1];
  lsf_token_t head;
  lsf_cfg_t   cfg_q;
  logic       adv;

  // whole row moves unless a finished result is held up at the output
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  // unused command code: accepted, but travels as a bubble
  always_comb begin
    head     = '0;
    head.vld = in_valid_i && (in_req_i.command != CMD_NONE);
    head.req = in_req_i;
  end

  assign chain[0] = head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BACK_EN:   cfg_q.back_en   <= cfg_wdata_i[0];
        REG_EXIT_MASK: cfg_q.exit_mask <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  for (genvar k = 0; k < ROUTE_ENTRIES; k++) begin : g_cell
    lsf_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .tok_i  (chain[k]),
      .tok_o  (chain[k+1])
    );
  end

  lsf_resolve #(
    .NUM_PORTS (NUM_PORTS)
  ) u_resolve (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .cfg_i       (cfg_q),
    .tok_i       (chain[ROUTE_ENTRIES]),
    .out_valid_o (out_valid_o),
    .out_res_o   (out_res_o)
  );

endmodule

>>> design/lsf_checker.sv
// Port-level checks for label_swap_forwarding, bound to the top level.
// Uses lsf_pkg.
module lsf_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input lsf_pkg::lsf_res_t out_res_o
);
  import lsf_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_res_o))
    else $error("stalled result changed");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("request side stalled without a held result");

  a_exit_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.exit_mark |->
      (out_res_o.verdict == V_FWD_EXIT) || (out_res_o.verdict == V_BACK_EXIT))
    else $error("exit mark on a non-exit verdict");

  a_no_fwd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_res_o.verdict != V_FWD) && (out_res_o.verdict != V_FWD_EXIT) &&
      (out_res_o.verdict != V_BACK_EXIT) |->
      (out_res_o.dest_port == '0) && (out_res_o.out_label == '0))
    else $error("dropped or command result carries a destination");

endmodule

bind label_swap_forwarding lsf_checker u_lsf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_res_o   (out_res_o)
);

>>> tb/lsf_route_checker.sv
`timescale 1ns / 100ps
// Checker for label_swap_forwarding: watches the request, result and register
// channels, predicts each result and compares it field by field.
// Depends on lsf_pkg only.
module lsf_route_checker #(
  parameter int unsigned NUM_PORTS     = 16,
  parameter int unsigned ROUTE_ENTRIES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  lsf_pkg::lsf_req_t in_req_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  lsf_pkg::lsf_res_t out_res_i,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_idx_i,
  input  logic [15:0]       cfg_wdata_i,
  output int unsigned       fail_cnt_o,
  output int unsigned       pending_o
);
  import lsf_pkg::*;

  // own copy of the route table, port state and registers
  logic               route_used [ROUTE_ENTRIES];
  logic [PortW-1:0]   key_port   [ROUTE_ENTRIES];
  logic [LabelW-1:0]  key_label  [ROUTE_ENTRIES];
  logic [PortW-1:0]   next_port  [ROUTE_ENTRIES];
  logic [LabelW-1:0]  next_label [ROUTE_ENTRIES];
  logic [PortCnt-1:0] down_mask;
  logic               back_en;
  logic [PortCnt-1:0] exit_mask;

  lsf_res_t    due_results [$];
  lsf_res_t    want_res;
  int unsigned mismatches = 0;

  assign fail_cnt_o = mismatches;

  task automatic report_mismatch(input string what, input logic [LabelW-1:0] got,
                                 input logic [LabelW-1:0] want);
    mismatches++;
    // keep the log short when the block is badly broken
    if (mismatches <= 100)
      $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  // Decision for one request; updates the table and port state as it goes.
  function automatic lsf_res_t route_decision(lsf_req_t r);
    lsf_res_t res;
    int       hit;
    int       free_slot;
    logic [PortW-1:0] d;
    res       = '0;
    hit       = -1;
    free_slot = -1;
    for (int k = 0; k < ROUTE_ENTRIES; k++) begin
      if (hit < 0 && route_used[k] && key_port[k] == r.in_port && key_label[k] == r.in_label)
        hit = k;
      if (free_slot < 0 && !route_used[k])
        free_slot = k;
    end
    case (r.command)
      CMD_FWD: begin
        if (!r.frame_ok) begin
          res.verdict = V_MALFORMED;
        end else if (hit >= 0) begin
          d = next_port[hit];
          if (d >= NUM_PORTS || down_mask[d]) begin
            res.verdict = V_TARGET_DOWN;
          end else begin
            res.dest_port = d;
            res.out_label = next_label[hit];
            res.exit_mark = exit_mask[d];
            res.verdict   = exit_mask[d] ? V_FWD_EXIT : V_FWD;
          end
        end else if (back_en) begin
          // back out of the ingress port, whatever its link state
          res.verdict   = V_BACK_EXIT;
          res.dest_port = r.in_port;
          res.out_label = r.in_label;
          res.exit_mark = 1'b1;
        end else begin
          res.verdict = V_MISS_DROP;
        end
      end
      CMD_WRITE: begin
        if (hit >= 0) begin
          res.verdict = V_DUPLICATE;
        end else if (free_slot < 0) begin
          res.verdict = V_FULL;
        end else begin
          route_used[free_slot] = 1'b1;
          key_port[free_slot]   = r.in_port;
          key_label[free_slot]  = r.in_label;
          next_port[free_slot]  = r.target_port;
          next_label[free_slot] = r.target_label;
          res.verdict           = V_STORED;
        end
      end
      default: begin
        if (r.in_port < NUM_PORTS)
          down_mask[r.in_port] = 1'b1;
        res.verdict = V_PORT_DOWNED;
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ROUTE_ENTRIES; k++)
        route_used[k] = 1'b0;
      down_mask = '0;
      back_en   = 1'b0;
      exit_mask = '0;
      due_results.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          report_mismatch("result with nothing due", LabelW'(out_res_i.verdict), '0);
        end else begin
          want_res = due_results.pop_front();
          if (out_res_i.verdict !== want_res.verdict)
            report_mismatch("verdict", LabelW'(out_res_i.verdict),
                            LabelW'(want_res.verdict));
          if (out_res_i.dest_port !== want_res.dest_port)
            report_mismatch("dest_port", LabelW'(out_res_i.dest_port),
                            LabelW'(want_res.dest_port));
          if (out_res_i.out_label !== want_res.out_label)
            report_mismatch("out_label", out_res_i.out_label, want_res.out_label);
          if (out_res_i.exit_mark !== want_res.exit_mark)
            report_mismatch("exit_mark", LabelW'(out_res_i.exit_mark),
                            LabelW'(want_res.exit_mark));
        end
      end
      // the unused command gives no result
      if (in_valid_i && !in_stall_i && in_req_i.command != CMD_NONE)
        due_results.insert(due_results.size(), route_decision(in_req_i));
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_BACK_EN)
          back_en = cfg_wdata_i[0];
        else if (cfg_idx_i == REG_EXIT_MASK)
          exit_mask = cfg_wdata_i[PortCnt-1:0];
      end
      pending_o <= due_results.size();
    end
  end

endmodule

>>> tb/label_swap_forwarding_test.sv
`timescale 1ns / 100ps
// Top of the label_swap_forwarding testbench: clock, reset, requests, register
// writes, random output stalls, watchdog and final verdict.
// Depends on lsf_pkg, label_swap_forwarding and lsf_route_checker.
module label_swap_forwarding_test;
  import lsf_pkg::*;

  localparam int unsigned Routes       = 64;
  localparam int unsigned Ports        = 16;
  // row of cells plus resolve stage, with some margin
  localparam int unsigned SettleCycles = Routes + 8;
  // worst quiet stretch is a settle pause plus a few stalls; this is far above
  localparam int unsigned IdleLimit    = 2000;
  localparam int unsigned PhaseItems   = 220;
  localparam int unsigned PhaseCnt     = 5;
  localparam logic [LabelW-1:0] AllOnes = '1;

  typedef struct packed {
    logic [PortW-1:0]  port;
    logic [LabelW-1:0] label;
  } route_key_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  lsf_req_t    in_req;
  logic        out_valid;
  logic        out_stall;
  lsf_res_t    out_res;
  logic        cfg_we;
  logic [0:0]  cfg_idx;
  logic [15:0] cfg_wdata;
  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned idle_cycles;

  // request-side idling is switched on and off in stretches
  logic        in_idle_en = 1'b1;
  int unsigned sent_cnt   = 0;
  route_key_t  known_keys [$];

  label_swap_forwarding #(
    .NUM_PORTS    (Ports),
    .ROUTE_ENTRIES(Routes)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_res_o  (out_res),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  lsf_route_checker #(
    .NUM_PORTS    (Ports),
    .ROUTE_ENTRIES(Routes)
  ) i_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_req_i   (in_req),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_res_i  (out_res),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: counts cycles in which neither channel moves a request/result.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("label_swap_forwarding_test NOT OK");
        $finish;
      end
    end
  end

  // Result side: a random stall before each result, in stretches, with
  // stretches of no stall at all.
  initial begin
    int unsigned hold;
    int unsigned served;
    logic        stall_en;
    out_stall = 1'b0;
    served    = 0;
    stall_en  = 1'b1;
    forever begin
      if (served % 40 == 0)
        stall_en = $urandom_range(0, 3) != 0;
      hold = stall_en ? $urandom_range(0, 7) : 0;
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      served++;
    end
  end

  function automatic lsf_req_t mk_req(lsf_cmd_e cmd, logic [PortW-1:0] port,
                                      logic [LabelW-1:0] label, logic ok,
                                      logic [PortW-1:0] tport, logic [LabelW-1:0] tlabel);
    lsf_req_t r;
    r.command      = cmd;
    r.in_port      = port;
    r.in_label     = label;
    r.frame_ok     = ok;
    r.target_port  = tport;
    r.target_label = tlabel;
    return r;
  endfunction

  // extremes, walking ones and full random labels
  function automatic logic [LabelW-1:0] pick_label();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return AllOnes;
      2, 3:    return 64'd1 << $urandom_range(0, LabelW - 1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Present one request after a random gap and hold it until taken.
  task automatic push_req(input lsf_req_t r);
    int unsigned gap;
    if (sent_cnt % 40 == 0)
      in_idle_en = $urandom_range(0, 3) != 0;
    gap = in_idle_en ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (in_stall);
    sent_cnt++;
  endtask

  // Hold off until every result is back and the row has emptied of
  // requests that give no result.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Both registers, back to back; only while the block is idle.
  task automatic apply_cfg(input logic back, input logic [15:0] mask);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_BACK_EN;
    cfg_wdata <= {15'd0, back};
    @(posedge clk);
    cfg_idx   <= REG_EXIT_MASK;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly lookups of keys already written and fresh route writes,
  // with malformed frames, unused commands and rare port downs mixed in.
  task automatic random_burst(input int unsigned count);
    lsf_req_t    r;
    int unsigned roll;
    int unsigned reuse;
    route_key_t  key;
    for (int unsigned n = 0; n < count; n++) begin
      roll = $urandom_range(0, 999);
      if (roll < 4)
        r.command = CMD_DOWN;
      else if (roll < 50)
        r.command = CMD_NONE;
      else if (roll < 300)
        r.command = CMD_WRITE;
      else
        r.command = CMD_FWD;
      reuse = (r.command == CMD_WRITE) ? 25 : 65;
      if (known_keys.size() != 0 && $urandom_range(0, 99) < reuse) begin
        key = known_keys[$urandom_range(0, known_keys.size() - 1)];
      end else begin
        key.port  = PortW'($urandom_range(0, Ports - 1));
        key.label = pick_label();
      end
      if (r.command == CMD_WRITE)
        known_keys.insert(known_keys.size(), key);
      r.in_port      = key.port;
      r.in_label     = key.label;
      r.frame_ok     = $urandom_range(0, 9) != 0;
      r.target_port  = PortW'($urandom_range(0, Ports - 1));
      r.target_label = pick_label();
      push_req(r);
    end
  endtask

  initial begin
    logic [15:0] masks [PhaseCnt];
    logic        backs [PhaseCnt];
    in_valid  = 1'b0;
    in_req    = '0;
    cfg_we    = 1'b0;
    cfg_idx   = REG_BACK_EN;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    masks = '{16'h0000, 16'hffff, 16'($urandom), 16'($urandom), 16'hffff};
    backs = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part: default-back on, ports 0 and 15 are exit ports
    apply_cfg(1'b1, 16'h8001);
    push_req(mk_req(CMD_FWD,   4'd3,  AllOnes, 1'b0, 4'd0, '0));    // malformed
    push_req(mk_req(CMD_FWD,   4'd0,  '0,      1'b1, 4'd0, '0));    // miss, back to 0
    push_req(mk_req(CMD_WRITE, 4'd0,  '0,      1'b1, 4'd15, AllOnes));
    push_req(mk_req(CMD_WRITE, 4'd15, AllOnes, 1'b1, 4'd0, '0));
    push_req(mk_req(CMD_WRITE, 4'd0,  '0,      1'b1, 4'd7, 64'd5)); // duplicate key
    push_req(mk_req(CMD_WRITE, 4'd3,  64'h0123_4567_89ab_cdef, 1'b1, 4'd5,
                    64'hfedc_ba98_7654_3210));
    push_req(mk_req(CMD_FWD,   4'd0,  '0,      1'b1, 4'd0, '0));    // hit, exit port 15
    push_req(mk_req(CMD_FWD,   4'd15, AllOnes, 1'b1, 4'd0, '0));    // hit, exit port 0
    push_req(mk_req(CMD_FWD,   4'd3,  64'h0123_4567_89ab_cdef, 1'b1, 4'd0, '0));
    push_req(mk_req(CMD_FWD,   4'd3,  64'h0123_4567_89ab_cdef, 1'b0, 4'd0, '0));
    push_req(mk_req(CMD_NONE,  4'd9,  AllOnes, 1'b1, 4'd15, AllOnes)); // no result
    push_req(mk_req(CMD_DOWN,  4'd15, '0,      1'b0, 4'd0, '0));
    push_req(mk_req(CMD_FWD,   4'd0,  '0,      1'b1, 4'd0, '0));    // target down
    push_req(mk_req(CMD_DOWN,  4'd15, AllOnes, 1'b1, 4'd15, AllOnes)); // downed twice
    push_req(mk_req(CMD_FWD,   4'd15, '0,      1'b1, 4'd0, '0));    // back to a down port
    push_req(mk_req(CMD_WRITE, 4'd15, '0,      1'b0, 4'd9, 64'h8000_0000_0000_0001));
    push_req(mk_req(CMD_FWD,   4'd15, '0,      1'b1, 4'd0, '0));    // now a hit
    settle();

    // random phases, each under its own register setting
    for (int unsigned p = 0; p < PhaseCnt; p++) begin
      apply_cfg(backs[p], masks[p]);
      random_burst(PhaseItems);
      settle();
    end

    if (fail_cnt == 0)
      $display("label_swap_forwarding_test OK");
    else
      $display("label_swap_forwarding_test NOT OK");
    $finish;
  end

endmodule
